// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_IMPLIES_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/bochs_pkg.sv -----
// ----------------------------------------------------------------------------
// bochs_pkg
// Shared types and constants for the byte offset to CHS converter
// ----------------------------------------------------------------------------
package bochs_pkg;

   localparam int SPT_W        = 6;   // sectors per track
   localparam int SPC_W        = 7;   // sectors per cylinder, up to two heads
   localparam int SHIFT_BASE   = 7;   // 128 byte minimum sector
   localparam int SHIFT_MAX    = 10;  // 1024 byte maximum sector
   localparam int CYL_W        = 8;
   localparam int LEN_OUT_W    = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 6;

   localparam logic [CYL_W-1:0] CYL_SAT = {CYL_W{1'b1}};

   localparam logic [1:0]       RST_SIZE_CODE = 2'd2;
   localparam logic [SPT_W-1:0] RST_SPT       = 6'd18;
   localparam logic [1:0]       RST_HEADS     = 2'd2;
   localparam logic [1:0]       RST_STEPS     = 2'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SECTOR_SIZE = 2'd0,
      CSR_SPT         = 2'd1,
      CSR_HEADS       = 2'd2,
      CSR_STEPS       = 2'd3
   } csr_index_type;

   // configuration after the zero and three special cases are folded in
   typedef struct packed {
      logic [1:0]       size_code;
      logic [SPT_W-1:0] spt;
      logic             two_heads;
      logic [1:0]       steps;
   } cfg_type;

   typedef struct packed {
      logic [CYL_W-1:0]     cylinder;
      logic                 head;
      logic [SPT_W-1:0]     sector;
      logic [CYL_W-1:0]     seek_track;
      logic [LEN_OUT_W-1:0] clipped_length;
      logic                 was_clipped;
      logic                 range_error;
   } rsp_word_type;

endpackage

// ----- hdl/bochs_if.sv -----
// ----------------------------------------------------------------------------
// bochs_if
// Request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bochs_req_if #(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [OFFSET_BITS-1:0] byte_offset;
   logic [LENGTH_BITS-1:0] transfer_length;

   modport source (output valid, output byte_offset, output transfer_length, input ready);
   modport sink   (input valid, input byte_offset, input transfer_length, output ready);
endinterface

interface bochs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  cylinder;
   logic        head;
   logic [5:0]  sector;
   logic [7:0]  seek_track;
   logic [15:0] clipped_length;
   logic        was_clipped;
   logic        range_error;

   modport source (output valid, output cylinder, output head, output sector,
                   output seek_track, output clipped_length, output was_clipped,
                   output range_error, input ready);
   modport sink   (input valid, input cylinder, input head, input sector,
                   input seek_track, input clipped_length, input was_clipped,
                   input range_error, output ready);
endinterface

// ----- hdl/bochs_div_step.sv -----
// ----------------------------------------------------------------------------
// bochs_div_step
// One registered restoring division step: one quotient bit per stage
// ----------------------------------------------------------------------------
module bochs_div_step
   import bochs_pkg::*;
#(
   parameter int QW      = 17,
   parameter int CARRY_W = 40
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [QW-1:0]      in_dvd,
   input  logic [SPT_W-1:0]   in_rem,
   input  logic [CARRY_W-1:0] in_carry,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [QW-1:0]      out_dvd,
   output logic [SPT_W-1:0]   out_rem,
   output logic [CARRY_W-1:0] out_carry
);

   logic               valid_ff, valid_in;
   logic [QW-1:0]      dvd_ff, dvd_in;
   logic [SPT_W-1:0]   rem_ff, rem_in;
   logic [CARRY_W-1:0] carry_ff;
   logic [SPT_W:0]     trial;
   logic               fits;

   assign in_ready = !valid_ff || out_ready;

   // shift next dividend bit into the partial remainder, quotient bit fills in from the right
   always_comb begin
      trial    = {in_rem, in_dvd[QW-1]};
      fits     = trial >= {1'b0, cfg.spt};
      rem_in   = fits ? SPT_W'(trial - {1'b0, cfg.spt}) : trial[SPT_W-1:0];
      dvd_in   = {in_dvd[QW-2:0], fits};
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dvd_ff   <= dvd_in;
         rem_ff   <= rem_in;
         carry_ff <= in_carry;
      end
   end

   assign out_valid = valid_ff;
   assign out_dvd   = dvd_ff;
   assign out_rem   = rem_ff;
   assign out_carry = carry_ff;

endmodule

// ----- hdl/bochs_post.sv -----
// ----------------------------------------------------------------------------
// bochs_post
// Splits the track quotient into cylinder and head, then forms the
// cylinder end, the clipped length and the saturated outputs
// ----------------------------------------------------------------------------
module bochs_post
   import bochs_pkg::*;
#(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [OFFSET_BITS-8:0]    in_quo,
   input  logic [SPT_W-1:0]          in_rem,
   input  logic [OFFSET_BITS-1:0]    in_offset,
   input  logic [LENGTH_BITS-1:0]    in_length,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rsp_word_type              out_word
);

   localparam int QW   = OFFSET_BITS - SHIFT_BASE;
   localparam int PW   = QW + 1 + SPC_W;
   localparam int TW   = QW + 2;
   localparam int EW   = PW + SHIFT_MAX;

   // stage a: cylinder split and both products
   logic                   a_valid_ff, a_valid_in;
   logic [QW-1:0]          a_cyl_ff, a_cyl_in;
   logic                   a_head_ff, a_head_in;
   logic [SPT_W-1:0]       a_sec_ff, a_sec_in;
   logic [TW-1:0]          a_track_ff, a_track_in;
   logic [PW-1:0]          a_prod_ff, a_prod_in;
   logic [OFFSET_BITS-1:0] a_off_ff;
   logic [LENGTH_BITS-1:0] a_len_ff;
   logic [SPC_W-1:0]       spc;
   logic                   a_ready;

   // stage b: output register
   logic                   b_valid_ff, b_valid_in;
   rsp_word_type           b_word_ff, b_word_in;
   logic                   b_ready;
   logic [EW-1:0]          cyl_end, end_pos, clipped;
   logic                   clip, cyl_big, track_big;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      spc        = cfg.two_heads ? {cfg.spt, 1'b0} : {1'b0, cfg.spt};
      a_cyl_in   = cfg.two_heads ? (in_quo >> 1) : in_quo;
      a_head_in  = cfg.two_heads & in_quo[0];
      a_sec_in   = in_rem + SPT_W'(1);
      a_track_in = TW'(a_cyl_in) * TW'(cfg.steps);
      a_prod_in  = PW'(PW'(a_cyl_in) + PW'(1)) * PW'(spc);
      a_valid_in = a_ready ? in_valid : a_valid_ff;
   end

   always_comb begin
      cyl_end   = EW'(a_prod_ff) << (SHIFT_BASE + int'(cfg.size_code));
      end_pos   = EW'(a_off_ff) + EW'(a_len_ff);
      clip      = end_pos > cyl_end;
      clipped   = clip ? (cyl_end - EW'(a_off_ff)) : EW'(a_len_ff);
      cyl_big   = |a_cyl_ff[QW-1:CYL_W];
      track_big = |a_track_ff[TW-1:CYL_W];

      b_word_in.cylinder       = cyl_big ? CYL_SAT : a_cyl_ff[CYL_W-1:0];
      b_word_in.head           = a_head_ff;
      b_word_in.sector         = a_sec_ff;
      b_word_in.seek_track     = track_big ? CYL_SAT : a_track_ff[CYL_W-1:0];
      b_word_in.clipped_length = clipped[LEN_OUT_W-1:0];
      b_word_in.was_clipped    = clip;
      b_word_in.range_error    = cyl_big || track_big;
      b_valid_in               = b_ready ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_cyl_ff   <= a_cyl_in;
         a_head_ff  <= a_head_in;
         a_sec_ff   <= a_sec_in;
         a_track_ff <= a_track_in;
         a_prod_ff  <= a_prod_in;
         a_off_ff   <= in_offset;
         a_len_ff   <= in_length;
      end
      if (b_ready && a_valid_ff) begin
         b_word_ff <= b_word_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_word  = b_word_ff;

endmodule

// ----- hdl/byte_offset_to_chs_with_clip.sv -----
// ----------------------------------------------------------------------------
// byte_offset_to_chs_with_clip
// Converts a byte offset and length to cylinder, head, sector and seek
// track, and clips the length at the end of the target cylinder
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  req_chan  in   valid / ready      byte_offset, transfer_length
//  rsp_chan  out  valid / ready      cylinder, head, sector, seek_track,
//                                    clipped_length, was_clipped, range_error
//  csr_*     in   csr_write_en       csr_index, csr_wdata
//
//  one word per cycle sustained while the response side takes words; the pipe is:
//  an entry register, one divider stage per sector-number bit, two output stages
//  every stage holds its word on a stall and takes a new one once it drains
//  synchronous active-high reset empties the pipe and loads the default geometry
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_offset_to_chs_with_clip
   import bochs_pkg::*;
#(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   bochs_req_if.sink             req_chan,
   bochs_rsp_if.source           rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QW      = OFFSET_BITS - SHIFT_BASE;
   localparam int CARRY_W = OFFSET_BITS + LENGTH_BITS;

   // configuration registers
   logic [1:0]       size_code_ff;
   logic [SPT_W-1:0] spt_ff;
   logic [1:0]       heads_ff;
   logic [1:0]       steps_ff;
   cfg_type          cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_code_ff <= RST_SIZE_CODE;
         spt_ff       <= RST_SPT;
         heads_ff     <= RST_HEADS;
         steps_ff     <= RST_STEPS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SECTOR_SIZE: size_code_ff <= csr_wdata[1:0];
            CSR_SPT:         spt_ff       <= csr_wdata[SPT_W-1:0];
            CSR_HEADS:       heads_ff     <= csr_wdata[1:0];
            CSR_STEPS:       steps_ff     <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // zero counts act as one, three heads act as two
   always_comb begin
      cfg.size_code = size_code_ff;
      cfg.spt       = (spt_ff == '0) ? SPT_W'(1) : spt_ff;
      cfg.two_heads = heads_ff[1];
      cfg.steps     = (steps_ff == '0) ? 2'd1 : steps_ff;
   end

   // entry stage: logical sector from the offset
   logic                   e_valid_ff, e_valid_in, e_ready;
   logic [QW-1:0]          e_lsec_ff;
   logic [CARRY_W-1:0]     e_carry_ff;

   // divider chain wiring, index k is the input of step k
   logic                   d_valid [QW+1];
   logic                   d_ready [QW+1];
   logic [QW-1:0]          d_dvd   [QW+1];
   logic [SPT_W-1:0]       d_rem   [QW+1];
   logic [CARRY_W-1:0]     d_carry [QW+1];

   assign e_ready       = !e_valid_ff || d_ready[0];
   assign req_chan.ready = e_ready;
   assign e_valid_in    = e_ready ? req_chan.valid : e_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_ready && req_chan.valid) begin
         e_lsec_ff  <= QW'(req_chan.byte_offset >> (SHIFT_BASE + int'(cfg.size_code)));
         e_carry_ff <= {req_chan.byte_offset, req_chan.transfer_length};
      end
   end

   assign d_valid[0] = e_valid_ff;
   assign d_dvd[0]   = e_lsec_ff;
   assign d_rem[0]   = '0;
   assign d_carry[0] = e_carry_ff;

   for (genvar k = 0; k < QW; k++) begin : g_div
      bochs_div_step #(
         .QW      (QW),
         .CARRY_W (CARRY_W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg),
         .in_valid  (d_valid[k]),
         .in_ready  (d_ready[k]),
         .in_dvd    (d_dvd[k]),
         .in_rem    (d_rem[k]),
         .in_carry  (d_carry[k]),
         .out_valid (d_valid[k+1]),
         .out_ready (d_ready[k+1]),
         .out_dvd   (d_dvd[k+1]),
         .out_rem   (d_rem[k+1]),
         .out_carry (d_carry[k+1])
      );
   end

   rsp_word_type rsp_word;

   bochs_post #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (d_valid[QW]),
      .in_ready  (d_ready[QW]),
      .in_quo    (d_dvd[QW]),
      .in_rem    (d_rem[QW]),
      .in_offset (d_carry[QW][CARRY_W-1:LENGTH_BITS]),
      .in_length (d_carry[QW][LENGTH_BITS-1:0]),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (rsp_word)
   );

   assign rsp_chan.cylinder       = rsp_word.cylinder;
   assign rsp_chan.head           = rsp_word.head;
   assign rsp_chan.sector         = rsp_word.sector;
   assign rsp_chan.seek_track     = rsp_word.seek_track;
   assign rsp_chan.clipped_length = rsp_word.clipped_length;
   assign rsp_chan.was_clipped    = rsp_word.was_clipped;
   assign rsp_chan.range_error    = rsp_word.range_error;

   `ASSERT_IMPLIES(a_sector_in_track, clock, reset, rsp_chan.valid,
      (rsp_chan.sector != '0) && (rsp_chan.sector <= cfg.spt),
      "sector outside the configured track")

   `ASSERT_IMPLIES(a_single_head, clock, reset, rsp_chan.valid && !cfg.two_heads,
      rsp_chan.head == 1'b0, "head one reported on a single-sided geometry")

   `ASSERT_IMPLIES(a_seek_one_step, clock, reset,
      rsp_chan.valid && (cfg.steps == 2'd1) && !rsp_chan.range_error,
      rsp_chan.seek_track == rsp_chan.cylinder, "seek track differs from cylinder")

   `ASSERT_IMPLIES_NEXT(a_entry_loaded, clock, reset, req_chan.valid && req_chan.ready,
      e_valid_ff, "accepted word missing from entry stage")

endmodule

// ----- verif/byte_offset_to_chs_with_clip_checker.sv -----
// ----------------------------------------------------------------------------
// chs_checker
// Watches the request and response channels of the CHS converter, keeps its
// own copy of the geometry registers, predicts the cylinder, head, sector,
// seek track and clipped length of every accepted request and compares each
// response word with the oldest prediction
// ----------------------------------------------------------------------------
module chs_checker
   import bochs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bochs_req_if                  req_mon,
   bochs_rsp_if                  rsp_mon,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatches,
   output int unsigned           words_waiting,
   output int unsigned           words_checked
);

   logic [1:0]       size_code;
   logic [SPT_W-1:0] spt_raw;
   logic [1:0]       heads_raw;
   logic [1:0]       steps_raw;

   rsp_word_type chs_q[$];

   function automatic rsp_word_type predict_chs(input logic [23:0] byte_off,
                                                input logic [15:0] xfer_len);
      longint unsigned spt_n, heads_n, steps_n, per_cyl, lsec, cyl, trk;
      longint unsigned cyl_end, head_n;
      int unsigned     shift;
      rsp_word_type    w;
      shift   = SHIFT_BASE + size_code;
      spt_n   = (spt_raw == 0) ? 1 : spt_raw;
      // zero heads act as one, three as two
      heads_n = (heads_raw == 0) ? 1 : ((heads_raw > 2) ? 2 : heads_raw);
      steps_n = (steps_raw == 0) ? 1 : steps_raw;
      per_cyl = spt_n * heads_n;
      lsec    = longint'(byte_off) >> shift;
      cyl     = lsec / per_cyl;
      head_n  = (lsec / spt_n) % heads_n;
      trk     = cyl * steps_n;
      // clip against the true cylinder, even when it saturates
      cyl_end = ((cyl + 1) * per_cyl) << shift;
      w.cylinder       = (cyl > 255) ? CYL_SAT : cyl[7:0];
      w.head           = head_n[0];
      w.sector         = 6'((lsec % spt_n) + 1);
      w.seek_track     = (trk > 255) ? CYL_SAT : trk[7:0];
      w.was_clipped    = (longint'(byte_off) + longint'(xfer_len)) > cyl_end;
      w.clipped_length = w.was_clipped ? 16'(cyl_end - byte_off) : xfer_len;
      w.range_error    = (cyl > 255) || (trk > 255);
      return w;
   endfunction

   function automatic int compare_field(input string field, input longint unsigned want,
                                        input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      int           bad;
      if (reset) begin
         size_code     <= RST_SIZE_CODE;
         spt_raw       <= RST_SPT;
         heads_raw     <= RST_HEADS;
         steps_raw     <= RST_STEPS;
         chs_q.delete();
         mismatches    <= 0;
         words_waiting <= 0;
         words_checked <= 0;
      end else begin
         bad = 0;
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_SECTOR_SIZE: size_code <= csr_wdata[1:0];
               CSR_SPT:         spt_raw   <= csr_wdata[SPT_W-1:0];
               CSR_HEADS:       heads_raw <= csr_wdata[1:0];
               CSR_STEPS:       steps_raw <= csr_wdata[1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (chs_q.size() == 0) begin
               $error("response word with no request outstanding");
               bad++;
            end else begin
               want = chs_q.pop_front();
               bad += compare_field("cylinder", want.cylinder, rsp_mon.cylinder);
               bad += compare_field("head", want.head, rsp_mon.head);
               bad += compare_field("sector", want.sector, rsp_mon.sector);
               bad += compare_field("seek_track", want.seek_track, rsp_mon.seek_track);
               bad += compare_field("clipped_length", want.clipped_length,
                                    rsp_mon.clipped_length);
               bad += compare_field("was_clipped", want.was_clipped, rsp_mon.was_clipped);
               bad += compare_field("range_error", want.range_error, rsp_mon.range_error);
               words_checked <= words_checked + 1;
            end
         end
         if (req_mon.valid && req_mon.ready)
            chs_q.push_back(predict_chs(req_mon.byte_offset, req_mon.transfer_length));
         mismatches    <= mismatches + bad;
         words_waiting <= chs_q.size();
      end
   end

endmodule

// ----- verif/byte_offset_to_chs_with_clip_tb.sv -----
// ----------------------------------------------------------------------------
// byte_offset_to_chs_with_clip_tb
// Drives byte offset and length requests into the CHS converter under a
// series of disk geometries, from the reset geometry through the extremes and
// the folded zero and three values to random ones; requests cluster around
// cylinder ends and the cylinder limits, both sides idle and stall at random,
// and the checker beside the block predicts and compares every response word
// ----------------------------------------------------------------------------
module byte_offset_to_chs_with_clip_tb;
   import bochs_pkg::*;

   localparam int STALL_LIMIT        = 5000;
   localparam int DRAIN_CYCLES       = 25;
   localparam int RANDOM_PER_SETTING = 175;
   localparam int GEOMETRIES         = 11;
   localparam int CORNERS            = 16;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_HALF,
      SINK_CHOKED,
      SINK_PERIODIC
   } sink_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int unsigned   mismatches;
   int unsigned   words_waiting;
   int unsigned   words_checked;
   int unsigned   requests_sent;
   int unsigned   idle_cycles = 0;
   int unsigned   burst_left;
   sink_mode_type sink_mode = SINK_OPEN;
   int unsigned   sink_left = 0;

   logic [1:0]       geo_code;
   logic [SPT_W-1:0] geo_spt;
   logic [1:0]       geo_heads;

   // corner requests under the reset geometry: 512 byte sectors, 18432 byte cylinders
   logic [23:0] corner_offsets [CORNERS] = '{
      24'd0, 24'd0, 24'hFFFFFF, 24'd18332, 24'd18332, 24'd18432, 24'd511, 24'd512,
      24'd9216, 24'd9215, 24'd4700160, 24'd4718592, 24'h555555, 24'hAAAAAA,
      24'h0000FF, 24'hFFFF00};
   logic [15:0] corner_lengths [CORNERS] = '{
      16'd0, 16'hFFFF, 16'hFFFF, 16'd100, 16'd101, 16'd0, 16'd1, 16'd0,
      16'd512, 16'd1, 16'd0, 16'd0, 16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00};

   bochs_req_if #(.OFFSET_BITS(24), .LENGTH_BITS(16)) req_chan ();
   bochs_rsp_if rsp_chan ();

   byte_offset_to_chs_with_clip #(
      .OFFSET_BITS (24),
      .LENGTH_BITS (16)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   chs_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .words_waiting (words_waiting),
      .words_checked (words_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: the stall mode is picked anew at random whenever its hold counter runs out
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_left <= $urandom_range(20, 300);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         SINK_OPEN:   rsp_chan.ready <= 1'b1;
         SINK_HALF:   rsp_chan.ready <= 1'($urandom_range(0, 1));
         SINK_CHOKED: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_chan.ready <= (sink_left[3:0] < 4'd9);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic longint cylinder_bytes();
      longint spt_n, heads_n;
      spt_n   = (geo_spt == 0) ? 1 : geo_spt;
      heads_n = (geo_heads == 0) ? 1 : ((geo_heads > 2) ? 2 : geo_heads);
      return (spt_n * heads_n) << (SHIFT_BASE + geo_code);
   endfunction

   task automatic pick_request(output logic [23:0] off, output logic [15:0] len);
      longint      cb, top_cyl, base, back, ofs, ln, cyl;
      int unsigned kind;
      cb      = cylinder_bytes();
      top_cyl = longint'(24'hFFFFFF) / cb;
      kind    = $urandom_range(0, 99);
      if (kind < 35) begin
         ofs = $urandom_range(0, 24'hFFFFFF);
         ln  = $urandom_range(0, 65535);
      end else if (kind < 70) begin
         // land just before a cylinder end, length around the distance to it
         base = cb * $urandom_range(1, (top_cyl < 300) ? top_cyl : 300);
         back = $urandom_range(0, 700);
         if (back > base)
            back = base;
         ofs = base - back;
         ln  = back + longint'($urandom_range(0, 4)) - 2;
         if ($urandom_range(0, 3) == 0)
            ln = $urandom_range(0, 65535);
      end else if (kind < 85) begin
         // cylinders where the cylinder or the seek track leaves 8 bits
         kind = $urandom_range(0, 3);
         cyl  = (kind < 2) ? 127 + kind : 253 + kind;
         ofs  = cyl * cb + $urandom_range(0, cb - 1);
         if (ofs > 24'hFFFFFF)
            ofs = $urandom_range(0, 24'hFFFFFF);
         ln = $urandom_range(0, 65535);
      end else begin
         ofs = $urandom_range(0, 4 * cb);
         ln  = $urandom_range(0, 2 * cb);
      end
      if (ofs > 24'hFFFFFF)
         ofs = 24'hFFFFFF;
      if (ln < 0)
         ln = 0;
      else if (ln > 65535)
         ln = 65535;
      off = ofs[23:0];
      len = ln[15:0];
   endtask

   task automatic send_request(input logic [23:0] off, input logic [15:0] len);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_chan.valid           <= 1'b1;
      req_chan.byte_offset     <= off;
      req_chan.transfer_length <= len;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [5:0] code, input logic [5:0] spt,
                               input logic [5:0] heads, input logic [5:0] steps);
      write_csr(CSR_SECTOR_SIZE, code);
      write_csr(CSR_SPT, spt);
      write_csr(CSR_HEADS, heads);
      write_csr(CSR_STEPS, steps);
      csr_write_en <= 1'b0;
      geo_code  = code[1:0];
      geo_spt   = spt;
      geo_heads = heads[1:0];
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
   endtask

   initial begin
      logic [23:0] off;
      logic [15:0] len;
      reset                    = 1'b1;
      csr_write_en             = 1'b0;
      csr_index                = '0;
      csr_wdata                = '0;
      req_chan.valid           = 1'b0;
      req_chan.byte_offset     = '0;
      req_chan.transfer_length = '0;
      rsp_chan.ready           = 1'b0;
      geo_code                 = RST_SIZE_CODE;
      geo_spt                  = RST_SPT;
      geo_heads                = RST_HEADS;
      burst_left               = 0;
      requests_sent            = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int g = 0; g < GEOMETRIES; g++) begin
         case (g)
            0: begin
               for (int i = 0; i < CORNERS; i++)
                  send_request(corner_offsets[i], corner_lengths[i]);
            end
            1: set_geometry(6'd0, 6'd1, 6'd1, 6'd1);
            2: set_geometry(6'd3, 6'd63, 6'd2, 6'd2);
            // zero sectors, heads and steps fold to one
            3: set_geometry(6'd1, 6'd0, 6'd0, 6'd0);
            // three heads act as two, three steps stay three; upper data bits ignored
            4: set_geometry(6'b111110, 6'd9, 6'b101011, 6'b110011);
            default: set_geometry(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                  6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
         endcase
         repeat (RANDOM_PER_SETTING) begin
            pick_request(off, len);
            send_request(off, len);
         end
         wait_drained();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests under %0d disk geometries, %0d response words compared",
               requests_sent, GEOMETRIES, words_checked);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- byte_offset_to_chs_with_clip.f -----
+incdir+hdl
hdl/bochs_pkg.sv
hdl/bochs_if.sv
hdl/bochs_div_step.sv
hdl/bochs_post.sv
hdl/byte_offset_to_chs_with_clip.sv
verif/byte_offset_to_chs_with_clip_checker.sv
verif/byte_offset_to_chs_with_clip_tb.sv
